// ===== sv/rpn_pkg.sv =====
// Shared types and constants for the RPN stack evaluator.
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        ACT_PUSH = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4,
        ACT_BAD  = 3'd5,
        ACT_EOL  = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_UNDER = 3'd1,
        ERR_FULL  = 3'd2,
        ERR_DIV0  = 3'd3,
        ERR_BAD   = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WB
    } state_t;

    // Shift command broadcast to every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

endpackage

// ===== sv/rpn_cell.sv =====
// One entry of the shifting operand stack.
module rpn_cell
    import rpn_pkg::*;
(
    input  logic                   clk,
    input  shift_t                 ctl,
    input  logic [VALUE_WIDTH-1:0] prev_value,
    input  logic [VALUE_WIDTH-1:0] next_value,
    output logic [VALUE_WIDTH-1:0] value
);

    logic [VALUE_WIDTH-1:0] value_reg;

    // A push moves every entry one place deeper, a pop one place up.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            value_reg <= prev_value;
        end
        else if (ctl.pop)
        begin
            value_reg <= next_value;
        end
    end

    assign value = value_reg;

endmodule

// ===== sv/rpn_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rpn_div
    import rpn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient
);

    localparam int W = VALUE_WIDTH;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W:0]       rem_reg, rem_next;
    logic [W:0]       rem_sh;
    logic [W:0]       diff;

    assign rem_sh = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[W-1] ^ divisor[W-1];
            dvs_next  = divisor[W-1] ? W'(-divisor) : divisor;
            quo_next  = dividend[W-1] ? W'(-dividend) : dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (diff[W])
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? W'(-quo_reg) : quo_reg;

endmodule

// ===== sv/rpn_stack_evaluator_core.sv =====
// Top level of the RPN stack evaluator: control, stack cells, divider, result register.
// Each request on the input stream is one RPN token and produces exactly one result
// request. The operand stack is a row of 16 cells that shift together, so push, add,
// subtract, bad token and end of line finish in the cycle they are accepted. Multiply
// goes through operand read, registered product and write-back. Divide runs on the
// 32-step iterative divider and then goes to the same write-back. The block works on one token
// at a time and accepts the next one only once the output register is empty or its
// result is taken in that same cycle. Errors stay until end of line, which reports the
// stack top, depth and error of the line and then empties the stack.
module rpn_stack_evaluator_core
    import rpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] operand_value
    input  logic [2:0]  s_axis_tuser,  // [2:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] top_value, [34:32] status, [39:35] stack_depth
    output logic        m_axis_tlast   // line_done
);

    localparam int W = VALUE_WIDTH;

    state_t          state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    err_t            err_reg, err_next;
    logic [W-1:0]    res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     top_reg, top_next;
    err_t            status_reg, status_next;
    logic [SP_W-1:0] depth_reg, depth_next;
    logic            last_reg, last_next;
    logic            out_load;

    shift_t          shift;
    logic [W-1:0]    cell_val [STACK_DEPTH];
    logic [W-1:0]    push_val;
    logic [W-1:0]    pop_val;
    logic [W-1:0]    x_val, y_val;
    logic [W-1:0]    alu_res;
    logic [W-1:0]    prod;
    logic [31:0]     top_now;
    logic            div_start;
    logic            div_done;
    logic [W-1:0]    div_quo;
    logic            in_accept;
    logic            out_free;
    action_t         act;

    assign act       = action_t'(s_axis_tuser);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign push_val = W'(signed'(s_axis_tdata));
    assign x_val    = cell_val[0];
    assign y_val    = cell_val[1];
    assign alu_res  = (act == ACT_SUB) ? (y_val - x_val) : (y_val + x_val);
    assign prod     = W'(y_val * x_val);
    assign top_now  = (sp_reg != '0) ? 32'(signed'(x_val)) : 32'd0;
    assign pop_val  = (state_reg == ST_WB) ? res_reg : alu_res;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [W-1:0] prev_in;
        logic [W-1:0] next_in;
        if (i == 0)
        begin : g_first
            assign prev_in = push_val;
            assign next_in = pop_val;
        end
        else if (i == STACK_DEPTH - 1)
        begin : g_last
            assign prev_in = cell_val[i-1];
            assign next_in = '0;
        end
        else
        begin : g_mid
            assign prev_in = cell_val[i-1];
            assign next_in = cell_val[i+1];
        end
        rpn_cell u_cell (
            .clk        (clk),
            .ctl        (shift),
            .prev_value (prev_in),
            .next_value (next_in),
            .value      (cell_val[i])
        );
    end

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (y_val),
        .divisor  (x_val),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        err_next    = err_reg;
        res_next    = res_reg;
        shift       = '0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        top_next    = top_now;
        status_next = err_reg;
        depth_next  = sp_reg;
        last_next   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    out_load = 1'b1;
                    if (act == ACT_EOL)
                    begin
                        last_next = 1'b1;
                        sp_next   = '0;
                        err_next  = ERR_NONE;
                    end
                    else if (err_reg != ERR_NONE)
                    begin
                        // Sticky error: the token is ignored.
                    end
                    else
                    begin
                        unique case (act)
                            ACT_PUSH:
                            begin
                                if (sp_reg == SP_W'(STACK_DEPTH))
                                begin
                                    err_next    = ERR_FULL;
                                    status_next = ERR_FULL;
                                end
                                else
                                begin
                                    shift.push = 1'b1;
                                    sp_next    = SP_W'(sp_reg + 1'b1);
                                    depth_next = sp_next;
                                    top_next   = 32'(signed'(push_val));
                                end
                            end
                            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV:
                            begin
                                if (sp_reg < SP_W'(2))
                                begin
                                    err_next    = ERR_UNDER;
                                    status_next = ERR_UNDER;
                                end
                                else if (act == ACT_MUL)
                                begin
                                    out_load   = 1'b0;
                                    state_next = ST_MUL;
                                end
                                else if (act == ACT_DIV)
                                begin
                                    if (x_val == '0)
                                    begin
                                        err_next    = ERR_DIV0;
                                        status_next = ERR_DIV0;
                                    end
                                    else
                                    begin
                                        out_load   = 1'b0;
                                        div_start  = 1'b1;
                                        state_next = ST_DIV;
                                    end
                                end
                                else
                                begin
                                    shift.pop  = 1'b1;
                                    sp_next    = SP_W'(sp_reg - 1'b1);
                                    depth_next = sp_next;
                                    top_next   = 32'(signed'(alu_res));
                                end
                            end
                            default:
                            begin
                                err_next    = ERR_BAD;
                                status_next = ERR_BAD;
                            end
                        endcase
                    end
                end
            end
            ST_MUL:
            begin
                res_next   = prod;
                state_next = ST_WB;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quo;
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    shift.pop  = 1'b1;
                    sp_next    = SP_W'(sp_reg - 1'b1);
                    depth_next = sp_next;
                    top_next   = 32'(signed'(res_reg));
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_axis_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (out_load)
        begin
            top_reg    <= top_next;
            status_reg <= status_next;
            depth_reg  <= depth_next;
            last_reg   <= last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'(depth_reg), 3'(status_reg), top_reg};
    assign m_axis_tlast  = last_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_eol_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && act == ACT_EOL) |=> (sp_reg == '0 && err_reg == ERR_NONE))
        else $error("end of line did not clear stack and error");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (x_val != '0 && sp_reg >= SP_W'(2)))
        else $error("divider started with zero divisor or short stack");

    a_err_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && act != ACT_EOL && err_reg != ERR_NONE)
            |=> ($stable(sp_reg) && $stable(err_reg) && state_reg == ST_IDLE))
        else $error("stack changed during sticky error");

endmodule
